// ===== rtl/core/gjm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjm_pkg
// shared types and constants of the gauss-jordan mod prime block
// ----------------------------------------------------------------------------
package gjm_pkg;

  localparam int VALUE_W = 31;
  localparam int IDX_W   = 2;
  localparam int DIM_W   = 3;
  localparam int MAX_DIM = 4;
  localparam int CNT_W   = 5;
  localparam int ADDR_W  = 2 * IDX_W;

  localparam logic [1:0] REG_PRIME = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  localparam logic KIND_MATRIX = 1'b0;
  localparam logic KIND_PIVOT  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   column_index;
    logic [VALUE_W-1:0] element_value;
    logic               load_done;
  } in_item_t;

  typedef struct packed {
    logic               entry_kind;
    logic [IDX_W-1:0]   out_row;
    logic [IDX_W-1:0]   out_column;
    logic [VALUE_W-1:0] out_value;
    logic [DIM_W-1:0]   matrix_rank;
    logic [VALUE_W-1:0] determinant;
    logic               final_result;
  } out_item_t;

  typedef struct packed {
    logic               go;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] p;
  } mm_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] res;
  } mm_rsp_t;

endpackage

// ===== rtl/core/gauss_jordan_mod_prime.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_jordan_mod_prime
// gauss-jordan elimination of a small matrix over integers modulo a prime
// ----------------------------------------------------------------------------
// usage:
//   configure prime_modulus, row_count and column_count through cfg_we,
//   cfg_index and cfg_data while the block is idle.
//   a request is taken when start is high and busy is low; it writes one
//   element, reduced modulo the prime, into the 4x4 matrix memory.
//   a load runs its reduction through the shared 31-step bit-serial modular
//   multiplier; no new request is taken until the reduced element is written.
//   the request with load_done set starts the run: re-reduction, pivot
//   search, row swaps, scaling by the pivot inverse (square and multiply),
//   elimination below and above, and the diagonal determinant pass.
//   every modular product goes through the shared multiplier; the matrix
//   memory is read one word per cycle with registered data.
//   results are rows*cols matrix entries in row-major order, then cols pivot
//   list entries, each valid for one cycle on out_valid; the receiver cannot
//   stall. busy stays high until the last one.
//   reset restores the register defaults, clears rank and pivots, sets determinant to one.
// ----------------------------------------------------------------------------
module gauss_jordan_mod_prime (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  gjm_pkg::in_item_t           in_data,
  output logic                        out_valid,
  output gjm_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [gjm_pkg::VALUE_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE, S_LD_W, S_PRE, S_PRE_M, S_PRE_W, S_COL, S_SRCH, S_SRCH_Q,
    S_SWP, S_SWP_A, S_SWP_B, S_SWP_C, S_PIV, S_PIV_Q, S_INV, S_INV_AW,
    S_INV_B, S_INV_BW, S_SCL, S_SCL_M, S_SCL_W, S_DET_W, S_ELIM, S_ROW_F,
    S_ROW_FQ, S_ROW_J, S_ROW_M, S_ROW_W, S_ROW_S, S_BK, S_BK_K, S_DG,
    S_DG_M, S_DG_W, S_OUT, S_OUT_M, S_OUT_P
  } state_t;

  localparam int VW = gjm_pkg::VALUE_W;
  localparam int DW = gjm_pkg::DIM_W;
  localparam int IW = gjm_pkg::IDX_W;

  state_t           state_r;
  logic [VW-1:0]    prime_r;
  logic [DW-1:0]    rows_r;
  logic [DW-1:0]    cols_r;
  logic [IW-1:0]    pivot_r [gjm_pkg::MAX_DIM];
  logic [DW-1:0]    rank_r;
  logic [VW-1:0]    det_r;
  logic [DW-1:0]    i_r, j_r, k_r, s_r, bi_r;
  logic [IW-1:0]    piv_r, dst_r, src_r, col_r, ld_row_r, ld_col_r;
  logic             back_r, ld_done_r;
  logic [VW-1:0]    f_r, h_r, iv_r, base_r, acc_r, e_r, t_r, prod_r;
  logic             out_valid_r;
  gjm_pkg::out_item_t out_r;

  logic [VW-1:0]    mem [gjm_pkg::MAX_DIM * gjm_pkg::MAX_DIM];
  logic [VW-1:0]    mem_q_r;
  logic [gjm_pkg::ADDR_W-1:0] mem_addr;
  logic             mem_we;
  logic [VW-1:0]    mem_wd;

  gjm_pkg::mm_req_t mm_req;
  gjm_pkg::mm_rsp_t mm_rsp;

  logic [VW-1:0]    p_eff;
  logic [DW-1:0]    m_eff, n_eff, kk;
  logic [VW-1:0]    sub_res;
  logic [VW:0]      sub_wide;

  function automatic logic [gjm_pkg::ADDR_W-1:0] addr_of(input logic [IW-1:0] r,
                                                        input logic [IW-1:0] c);
    return {r, c};
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    if (v == '0) return DW'(1);
    if (v > DW'(gjm_pkg::MAX_DIM)) return DW'(gjm_pkg::MAX_DIM);
    return v;
  endfunction

  assign p_eff = (prime_r < VW'(2)) ? VW'(2) : prime_r;
  assign m_eff = clamp_dim(rows_r);
  assign n_eff = clamp_dim(cols_r);
  assign kk    = (n_eff < m_eff) ? n_eff : m_eff;

  // modular subtract of the product from the stored entry
  always_comb begin
    if (mem_q_r >= prod_r) sub_wide = {1'b0, mem_q_r} - {1'b0, prod_r};
    else sub_wide = {1'b0, mem_q_r} + {1'b0, p_eff} - {1'b0, prod_r};
    sub_res = sub_wide[VW-1:0];
  end

  gjm_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // memory port and multiplier requests
  always_comb begin
    mem_addr  = '0;
    mem_we    = 1'b0;
    mem_wd    = mm_rsp.res;
    mm_req.go = 1'b0;
    mm_req.a  = mem_q_r;
    mm_req.b  = VW'(1);
    mm_req.p  = p_eff;
    case (state_r)
      S_IDLE: begin
        mm_req.go = start;
        mm_req.a  = in_data.element_value;
      end
      S_LD_W: begin
        mem_addr = addr_of(ld_row_r, ld_col_r);
        mem_we   = mm_rsp.done;
      end
      S_PRE:   mem_addr = addr_of(i_r[IW-1:0], j_r[IW-1:0]);
      S_PRE_M: mm_req.go = 1'b1;
      S_PRE_W: begin
        mem_addr = addr_of(i_r[IW-1:0], j_r[IW-1:0]);
        mem_we   = mm_rsp.done;
      end
      S_SRCH:  mem_addr = addr_of(i_r[IW-1:0], s_r[IW-1:0]);
      S_SWP:   mem_addr = addr_of(piv_r, j_r[IW-1:0]);
      S_SWP_A: mem_addr = addr_of(rank_r[IW-1:0], j_r[IW-1:0]);
      S_SWP_B: begin
        mem_addr = addr_of(piv_r, j_r[IW-1:0]);
        mem_we   = 1'b1;
        mem_wd   = mem_q_r;
      end
      S_SWP_C: begin
        mem_addr = addr_of(rank_r[IW-1:0], j_r[IW-1:0]);
        mem_we   = 1'b1;
        mem_wd   = t_r;
      end
      S_PIV: mem_addr = addr_of(rank_r[IW-1:0], s_r[IW-1:0]);
      S_INV: begin
        mm_req.go = (e_r != '0) && e_r[0];
        mm_req.a  = acc_r;
        mm_req.b  = base_r;
      end
      S_INV_B: begin
        mm_req.go = 1'b1;
        mm_req.a  = base_r;
        mm_req.b  = base_r;
      end
      S_SCL: begin
        mem_addr  = addr_of(rank_r[IW-1:0], j_r[IW-1:0]);
        mm_req.go = (j_r >= n_eff);
        mm_req.a  = det_r;
        mm_req.b  = h_r;
      end
      S_SCL_M: begin
        mm_req.go = 1'b1;
        mm_req.b  = iv_r;
      end
      S_SCL_W: begin
        mem_addr = addr_of(rank_r[IW-1:0], j_r[IW-1:0]);
        mem_we   = mm_rsp.done;
      end
      S_ROW_F: mem_addr = addr_of(dst_r, col_r);
      S_ROW_J: begin
        if (j_r >= n_eff) begin
          mem_addr = addr_of(dst_r, col_r);
          mem_we   = back_r;
          mem_wd   = '0;
        end else begin
          mem_addr = addr_of(src_r, j_r[IW-1:0]);
        end
      end
      S_ROW_M: begin
        mm_req.go = 1'b1;
        mm_req.a  = f_r;
        mm_req.b  = mem_q_r;
      end
      S_ROW_W: mem_addr = addr_of(dst_r, j_r[IW-1:0]);
      S_ROW_S: begin
        mem_addr = addr_of(dst_r, j_r[IW-1:0]);
        mem_we   = 1'b1;
        mem_wd   = sub_res;
      end
      S_DG: mem_addr = addr_of(i_r[IW-1:0], i_r[IW-1:0]);
      S_DG_M: begin
        mm_req.go = 1'b1;
        mm_req.a  = det_r;
        mm_req.b  = mem_q_r;
      end
      S_OUT: mem_addr = addr_of(i_r[IW-1:0], j_r[IW-1:0]);
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prime_r     <= VW'(2147483647);
      rows_r      <= DW'(4);
      cols_r      <= DW'(4);
      rank_r      <= '0;
      det_r       <= VW'(1);
      out_valid_r <= 1'b0;
      for (int q = 0; q < gjm_pkg::MAX_DIM; q++) pivot_r[q] <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          gjm_pkg::REG_PRIME: prime_r <= cfg_data;
          gjm_pkg::REG_ROWS:  rows_r  <= cfg_data[DW-1:0];
          gjm_pkg::REG_COLS:  cols_r  <= cfg_data[DW-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            ld_row_r  <= in_data.row_index;
            ld_col_r  <= in_data.column_index;
            ld_done_r <= in_data.load_done;
            state_r   <= S_LD_W;
          end
        end
        S_LD_W: begin
          if (mm_rsp.done) begin
            if (ld_done_r) begin
              for (int q = 0; q < gjm_pkg::MAX_DIM; q++) pivot_r[q] <= '0;
              det_r   <= VW'(1);
              rank_r  <= '0;
              i_r     <= '0;
              j_r     <= '0;
              state_r <= S_PRE;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_PRE:   state_r <= S_PRE_M;
        S_PRE_M: state_r <= S_PRE_W;
        S_PRE_W: begin
          if (mm_rsp.done) begin
            if (j_r + 1'b1 >= n_eff) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
              if (i_r + 1'b1 >= m_eff) begin
                s_r     <= '0;
                state_r <= S_COL;
              end else begin
                state_r <= S_PRE;
              end
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_PRE;
            end
          end
        end
        S_COL: begin
          if (s_r >= n_eff) begin
            bi_r    <= rank_r;
            state_r <= S_BK;
          end else begin
            i_r     <= rank_r;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (i_r >= m_eff) begin
            s_r     <= s_r + 1'b1;
            state_r <= S_COL;
          end else begin
            state_r <= S_SRCH_Q;
          end
        end
        S_SRCH_Q: begin
          if (mem_q_r != '0) begin
            piv_r                   <= i_r[IW-1:0];
            pivot_r[rank_r[IW-1:0]] <= s_r[IW-1:0];
            j_r                     <= '0;
            state_r                 <= (i_r == rank_r) ? S_PIV : S_SWP;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_SWP:   state_r <= S_SWP_A;
        S_SWP_A: begin
          t_r     <= mem_q_r;
          state_r <= S_SWP_B;
        end
        S_SWP_B: state_r <= S_SWP_C;
        S_SWP_C: begin
          j_r <= j_r + 1'b1;
          if (j_r + 1'b1 >= n_eff) begin
            det_r   <= (det_r == '0) ? '0 : p_eff - det_r;
            state_r <= S_PIV;
          end else begin
            state_r <= S_SWP;
          end
        end
        S_PIV: state_r <= S_PIV_Q;
        S_PIV_Q: begin
          h_r <= mem_q_r;
          if (mem_q_r == VW'(1)) begin
            i_r     <= rank_r + 1'b1;
            state_r <= S_ELIM;
          end else begin
            base_r  <= mem_q_r;
            acc_r   <= VW'(1);
            e_r     <= p_eff - VW'(2);
            state_r <= S_INV;
          end
        end
        S_INV: begin
          if (e_r == '0) begin
            iv_r    <= acc_r;
            j_r     <= s_r;
            state_r <= S_SCL;
          end else if (e_r[0]) begin
            state_r <= S_INV_AW;
          end else begin
            state_r <= S_INV_B;
          end
        end
        S_INV_AW: begin
          if (mm_rsp.done) begin
            acc_r   <= mm_rsp.res;
            state_r <= S_INV_B;
          end
        end
        S_INV_B: state_r <= S_INV_BW;
        S_INV_BW: begin
          if (mm_rsp.done) begin
            base_r  <= mm_rsp.res;
            e_r     <= e_r >> 1;
            state_r <= S_INV;
          end
        end
        S_SCL:   state_r <= (j_r >= n_eff) ? S_DET_W : S_SCL_M;
        S_SCL_M: state_r <= S_SCL_W;
        S_SCL_W: begin
          if (mm_rsp.done) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SCL;
          end
        end
        S_DET_W: begin
          if (mm_rsp.done) begin
            det_r   <= mm_rsp.res;
            i_r     <= rank_r + 1'b1;
            state_r <= S_ELIM;
          end
        end
        S_ELIM: begin
          if (i_r >= m_eff) begin
            rank_r  <= rank_r + 1'b1;
            s_r     <= s_r + 1'b1;
            state_r <= S_COL;
          end else begin
            dst_r   <= i_r[IW-1:0];
            src_r   <= rank_r[IW-1:0];
            col_r   <= s_r[IW-1:0];
            back_r  <= 1'b0;
            state_r <= S_ROW_F;
          end
        end
        S_ROW_F: state_r <= S_ROW_FQ;
        S_ROW_FQ: begin
          f_r     <= mem_q_r;
          j_r     <= back_r ? {1'b0, col_r} + 1'b1 : {1'b0, col_r};
          state_r <= S_ROW_J;
        end
        S_ROW_J: begin
          if (j_r >= n_eff) begin
            if (back_r) begin
              k_r     <= k_r + 1'b1;
              state_r <= S_BK_K;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_ELIM;
            end
          end else begin
            state_r <= S_ROW_M;
          end
        end
        S_ROW_M: state_r <= S_ROW_W;
        S_ROW_W: begin
          if (mm_rsp.done) begin
            prod_r  <= mm_rsp.res;
            state_r <= S_ROW_S;
          end
        end
        S_ROW_S: begin
          j_r     <= j_r + 1'b1;
          state_r <= S_ROW_J;
        end
        S_BK: begin
          if (bi_r <= DW'(1)) begin
            i_r     <= '0;
            state_r <= S_DG;
          end else begin
            src_r   <= IW'(bi_r - 1'b1);
            col_r   <= pivot_r[IW'(bi_r - 1'b1)];
            k_r     <= '0;
            state_r <= S_BK_K;
          end
        end
        S_BK_K: begin
          if (k_r >= bi_r - 1'b1) begin
            bi_r    <= bi_r - 1'b1;
            state_r <= S_BK;
          end else begin
            dst_r   <= k_r[IW-1:0];
            back_r  <= 1'b1;
            state_r <= S_ROW_F;
          end
        end
        S_DG: begin
          if (i_r >= kk) begin
            i_r     <= '0;
            j_r     <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DG_M;
          end
        end
        S_DG_M: state_r <= S_DG_W;
        S_DG_W: begin
          if (mm_rsp.done) begin
            det_r   <= mm_rsp.res;
            i_r     <= i_r + 1'b1;
            state_r <= S_DG;
          end
        end
        S_OUT: state_r <= S_OUT_M;
        S_OUT_M: begin
          out_valid_r        <= 1'b1;
          out_r.entry_kind   <= gjm_pkg::KIND_MATRIX;
          out_r.out_row      <= i_r[IW-1:0];
          out_r.out_column   <= j_r[IW-1:0];
          out_r.out_value    <= mem_q_r;
          out_r.matrix_rank  <= rank_r;
          out_r.determinant  <= det_r;
          out_r.final_result <= 1'b0;
          if (j_r + 1'b1 >= n_eff) begin
            j_r <= '0;
            i_r <= i_r + 1'b1;
            state_r <= (i_r + 1'b1 >= m_eff) ? S_OUT_P : S_OUT;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT_P: begin
          out_valid_r        <= 1'b1;
          out_r.entry_kind   <= gjm_pkg::KIND_PIVOT;
          out_r.out_row      <= j_r[IW-1:0];
          out_r.out_column   <= '0;
          out_r.out_value    <= (j_r < rank_r) ? VW'(pivot_r[j_r[IW-1:0]]) : '0;
          out_r.matrix_rank  <= rank_r;
          out_r.determinant  <= det_r;
          out_r.final_result <= (j_r + 1'b1 >= n_eff);
          j_r                <= j_r + 1'b1;
          if (j_r + 1'b1 >= n_eff) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/gjm_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjm_modmul
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module gjm_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  gjm_pkg::mm_req_t req,
  output gjm_pkg::mm_rsp_t rsp
);

  logic [gjm_pkg::VALUE_W-1:0] acc_r;
  logic [gjm_pkg::VALUE_W-1:0] a_r;
  logic [gjm_pkg::VALUE_W-1:0] b_r;
  logic [gjm_pkg::VALUE_W-1:0] p_r;
  logic [gjm_pkg::CNT_W-1:0]   cnt_r;
  logic                        run_r;
  logic                        done_r;
  logic [gjm_pkg::VALUE_W:0]   t1;
  logic [gjm_pkg::VALUE_W:0]   t1r;
  logic [gjm_pkg::VALUE_W+1:0] t2;
  logic [gjm_pkg::VALUE_W+1:0] t2r;

  always_comb begin
    t1  = {acc_r, 1'b0};
    t1r = (t1 >= {1'b0, p_r}) ? t1 - {1'b0, p_r} : t1;
    t2  = {1'b0, t1r} + (a_r[gjm_pkg::VALUE_W-1] ? {2'b00, b_r} : '0);
    t2r = (t2 >= {2'b00, p_r}) ? t2 - {2'b00, p_r} : t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        a_r   <= req.a;
        b_r   <= req.b;
        p_r   <= req.p;
        acc_r <= '0;
        cnt_r <= gjm_pkg::CNT_W'(gjm_pkg::VALUE_W);
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= t2r[gjm_pkg::VALUE_W-1:0];
        a_r   <= {a_r[gjm_pkg::VALUE_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == gjm_pkg::CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

// ===== test/gjm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjm_checker
// request, result and register watcher for gauss_jordan_mod_prime: local
// store and registers, full run prediction on the closing request, field
// compare of each result strobe against the oldest expected result
// ----------------------------------------------------------------------------
module gjm_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  gjm_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  gjm_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [gjm_pkg::VALUE_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending_count,
  output int                          results_seen,
  output int                          runs_seen
);

  localparam int VW = gjm_pkg::VALUE_W;
  localparam int DW = gjm_pkg::DIM_W;
  localparam int IW = gjm_pkg::IDX_W;
  localparam int MD = gjm_pkg::MAX_DIM;

  typedef longint unsigned u64_t;

  u64_t               modulus;
  logic [DW-1:0]      rows_reg;
  logic [DW-1:0]      cols_reg;
  u64_t               mat [MD*MD];
  u64_t               piv_col [MD];
  u64_t               rank_q;
  u64_t               det_q;
  gjm_pkg::out_item_t expected_q [$];

  assign pending_count = expected_q.size();

  function automatic u64_t field_mod();
    return (modulus < 2) ? 2 : modulus;
  endfunction

  function automatic int clamp_size(logic [DW-1:0] v);
    if (v < 1) return 1;
    if (v > MD) return MD;
    return int'(v);
  endfunction

  function automatic u64_t mulm(u64_t a, u64_t b, u64_t p);
    return (a * b) % p;
  endfunction

  function automatic u64_t subm(u64_t a, u64_t b, u64_t p);
    return (a + p - b) % p;
  endfunction

  function automatic u64_t invm(u64_t h, u64_t p);
    u64_t e, base, acc;
    e = p - 2;
    base = h % p;
    acc = 1 % p;
    while (e != 0) begin
      if (e[0]) acc = mulm(acc, base, p);
      base = mulm(base, base, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  // full elimination on the local store, then queue the result stream
  task automatic predict_run();
    int   m, n, r, piv, kmin;
    u64_t p, d, h, iv, f, t;
    bit   found;
    int   pc;
    gjm_pkg::out_item_t o;
    p = field_mod();
    m = clamp_size(rows_reg);
    n = clamp_size(cols_reg);
    d = 1 % p;
    r = 0;
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++) mat[i*MD+j] = mat[i*MD+j] % p;
    for (int i = 0; i < MD; i++) piv_col[i] = 0;
    for (int s = 0; s < n; s++) begin
      found = 0;
      piv = 0;
      for (int i = r; i < m; i++)
        if (!found && mat[i*MD+s] != 0) begin
          piv = i;
          found = 1;
        end
      if (!found) continue;
      piv_col[r] = s;
      if (piv != r) begin
        for (int j = 0; j < n; j++) begin
          t = mat[piv*MD+j];
          mat[piv*MD+j] = mat[r*MD+j];
          mat[r*MD+j] = t;
        end
        d = subm(0, d, p);
      end
      h = mat[r*MD+s];
      if (h != 1) begin
        iv = invm(h, p);
        for (int j = s; j < n; j++) mat[r*MD+j] = mulm(mat[r*MD+j], iv, p);
        d = mulm(d, h, p);
      end
      for (int i = r + 1; i < m; i++) begin
        f = mat[i*MD+s];
        for (int j = s; j < n; j++)
          mat[i*MD+j] = subm(mat[i*MD+j], mulm(f, mat[r*MD+j], p), p);
      end
      r++;
    end
    // back-substitution above each pivot
    for (int i = r - 1; i >= 1; i--) begin
      pc = int'(piv_col[i]);
      for (int k = 0; k < i; k++) begin
        f = mat[k*MD+pc];
        for (int j = pc + 1; j < n; j++)
          mat[k*MD+j] = subm(mat[k*MD+j], mulm(f, mat[i*MD+j], p), p);
        mat[k*MD+pc] = 0;
      end
    end
    kmin = (n < m) ? n : m;
    for (int i = 0; i < kmin; i++) d = mulm(d, mat[i*MD+i], p);
    rank_q = r;
    det_q = d;
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++) begin
        o.entry_kind   = gjm_pkg::KIND_MATRIX;
        o.out_row      = i[IW-1:0];
        o.out_column   = j[IW-1:0];
        o.out_value    = mat[i*MD+j][VW-1:0];
        o.matrix_rank  = rank_q[DW-1:0];
        o.determinant  = det_q[VW-1:0];
        o.final_result = 1'b0;
        expected_q.push_back(o);
      end
    for (int j = 0; j < n; j++) begin
      o.entry_kind   = gjm_pkg::KIND_PIVOT;
      o.out_row      = j[IW-1:0];
      o.out_column   = '0;
      o.out_value    = (j < rank_q) ? VW'(piv_col[j]) : '0;
      o.matrix_rank  = rank_q[DW-1:0];
      o.determinant  = det_q[VW-1:0];
      o.final_result = (j == n - 1);
      expected_q.push_back(o);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    gjm_pkg::out_item_t e;
    if (!rst_n) begin
      modulus  <= 64'd2147483647;
      rows_reg <= 3'd4;
      cols_reg <= 3'd4;
      for (int i = 0; i < MD; i++) piv_col[i] = 0;
      rank_q = 0;
      det_q  = 1;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gjm_pkg::REG_PRIME: modulus  <= u64_t'(cfg_data);
          gjm_pkg::REG_ROWS:  rows_reg <= cfg_data[DW-1:0];
          gjm_pkg::REG_COLS:  cols_reg <= cfg_data[DW-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report("unexpected result value", out_data.out_value, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_data.entry_kind !== e.entry_kind)
            report("entry_kind", out_data.entry_kind, e.entry_kind);
          if (out_data.out_row !== e.out_row) report("out_row", out_data.out_row, e.out_row);
          if (out_data.out_column !== e.out_column)
            report("out_column", out_data.out_column, e.out_column);
          if (out_data.out_value !== e.out_value)
            report("out_value", out_data.out_value, e.out_value);
          if (out_data.matrix_rank !== e.matrix_rank)
            report("matrix_rank", out_data.matrix_rank, e.matrix_rank);
          if (out_data.determinant !== e.determinant)
            report("determinant", out_data.determinant, e.determinant);
          if (out_data.final_result !== e.final_result)
            report("final_result", out_data.final_result, e.final_result);
        end
      end
      if (start && !busy) begin
        mat[in_data.row_index*MD+in_data.column_index] =
          u64_t'(in_data.element_value) % field_mod();
        if (in_data.load_done) begin
          runs_seen++;
          predict_run();
        end
      end
    end
  end

  initial begin
    fail_count   = 0;
    results_seen = 0;
    runs_seen    = 0;
  end

endmodule

// ===== test/tb_gauss_jordan_mod_prime.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gauss_jordan_mod_prime
// request and register stimulus for gauss_jordan_mod_prime: directed opening
// over full-range values, small, composite and out-of-range moduli and out-of-range sizes, then random
// loads under several sender idle rates; checking lives in gjm_checker
// ----------------------------------------------------------------------------
module tb_gauss_jordan_mod_prime;

  localparam int         VW = gjm_pkg::VALUE_W;
  localparam int         MD = gjm_pkg::MAX_DIM;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 20000000;
  localparam int         RANDOM_ITEMS = 310;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  gjm_pkg::in_item_t  in_data;
  logic               out_valid;
  gjm_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [VW-1:0]      cfg_data;

  int fail_count, pending_count, results_seen, runs_seen;
  int items_sent;
  int idle_pct;
  int cycles;
  logic [VW-1:0] cur_prime;

  gauss_jordan_mod_prime dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gjm_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .results_seen(results_seen), .runs_seen(runs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_request(logic [1:0] r, logic [1:0] c, logic [VW-1:0] v,
                              logic done);
    gjm_pkg::in_item_t it;
    it.row_index     = r;
    it.column_index  = c;
    it.element_value = v;
    it.load_done     = done;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // every expected result in, plus the tail of a load with no result
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0 || busy);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [VW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == gjm_pkg::REG_PRIME) cur_prime = d;
  endtask

  function automatic logic [VW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return VW'($urandom_range(0, 3));
      4:          return cur_prime;
      5:          return cur_prime - 1'b1;
      default:    return VW'($urandom);
    endcase
  endfunction

  function automatic logic [VW-1:0] pick_prime();
    case ($urandom_range(0, 11))
      0:       return 31'd2;
      1:       return 31'd3;
      2:       return 31'd5;
      3:       return 31'd7;
      4:       return 31'd13;
      5:       return 31'd65521;
      6:       return 31'd2147483647;
      7:       return 31'd1000000007;
      8:       return VW'($urandom_range(0, 1));
      9:       return 31'd15;
      10:      return VW'($urandom);
      default: return 31'd11;
    endcase
  endfunction

  function automatic logic [VW-1:0] pick_size();
    if ($urandom_range(0, 99) < 10) return VW'($urandom_range(0, 7));
    return VW'($urandom_range(1, 4));
  endfunction

  initial begin
    logic [VW-1:0] v;
    int            k;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cycles     = 0;
    items_sent = 0;
    idle_pct   = 0;
    cur_prime  = 31'h7fffffff;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // whole store written once, full-range values, default sizes and modulus
    for (int i = 0; i < MD * MD; i++) begin
      case (i % 5)
        0: v = '0;
        1: v = 31'h7fffffff;
        2: v = 31'h7ffffffe;
        3: v = 31'd1;
        default: v = VW'($urandom);
      endcase
      send_request(2'(i / MD), 2'(i % MD), v, i == MD * MD - 1);
    end
    wait_idle();

    // small prime, wide matrix
    write_reg(gjm_pkg::REG_PRIME, 31'd7);
    write_reg(gjm_pkg::REG_ROWS, 31'd3);
    write_reg(gjm_pkg::REG_COLS, 31'd4);
    send_request(2'd0, 2'd0, 31'd0, 1'b0);
    send_request(2'd3, 2'd3, 31'h7fffffff, 1'b1);
    wait_idle();

    // modulus changed between the loads and the closing request
    send_request(2'd1, 2'd1, 31'd9, 1'b0);
    wait_idle();
    write_reg(gjm_pkg::REG_PRIME, 31'd0);
    write_reg(gjm_pkg::REG_ROWS, 31'd0);
    write_reg(gjm_pkg::REG_COLS, 31'd7);
    send_request(2'd2, 2'd1, 31'd5, 1'b1);
    wait_idle();

    // composite modulus, unused register index, tall matrix
    write_reg(gjm_pkg::REG_PRIME, 31'd15);
    write_reg(REG_UNUSED, 31'h7fffffff);
    write_reg(gjm_pkg::REG_ROWS, 31'd4);
    write_reg(gjm_pkg::REG_COLS, 31'd2);
    send_request(2'd0, 2'd0, 31'd6, 1'b0);
    send_request(2'd1, 2'd0, 31'd10, 1'b1);
    wait_idle();

    // all-zero 2x2 gives rank zero
    write_reg(gjm_pkg::REG_PRIME, 31'd1);
    write_reg(gjm_pkg::REG_ROWS, 31'd2);
    write_reg(gjm_pkg::REG_COLS, 31'd2);
    for (int i = 0; i < 4; i++) send_request(2'(i / 2), 2'(i % 2), 31'd0, i == 3);
    wait_idle();

    // random loads, three idle phases
    while (items_sent < RANDOM_ITEMS + 25) begin
      k = items_sent - 25;
      idle_pct = (k < RANDOM_ITEMS / 3) ? 0 : (k < 2 * RANDOM_ITEMS / 3) ? 49 : 8;
      if ($urandom_range(0, 2) == 0) write_reg(gjm_pkg::REG_PRIME, pick_prime());
      if ($urandom_range(0, 1) == 0) write_reg(gjm_pkg::REG_ROWS, pick_size());
      if ($urandom_range(0, 1) == 0) write_reg(gjm_pkg::REG_COLS, pick_size());
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++)
        send_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_value(),
                     i == k - 1);
      wait_idle();
    end

    $display("covered %0d requests in %0d runs, %0d results checked",
             items_sent, runs_seen, results_seen);
    $display("moduli from 0 to 2^31-1 incl. composite, sizes 0..7, idle rates 0/49/8 pct");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
